FILE: rtl/attribute_value_matcher_unit_defines.svh
// assertion macros for the attribute value matcher
// used by the files that carry concurrent assertions; no other dependencies
`ifndef ATTRIBUTE_VALUE_MATCHER_UNIT_DEFINES_SVH
`define ATTRIBUTE_VALUE_MATCHER_UNIT_DEFINES_SVH

// same-cycle implication, checked at every clock edge out of reset
`define AVM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("avm assertion failed");

// next-cycle implication, checked at every clock edge out of reset
`define AVM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("avm assertion failed");

`endif

FILE: rtl/avm_pkg.sv
// shared constants, operator codes and control types of the attribute value matcher
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package avm_pkg;

   // needle store depth and derived widths
   localparam int NEEDLE_MAX = 16;
   localparam int LEN_W      = $clog2(NEEDLE_MAX + 1);
   localparam int POS_SAT    = NEEDLE_MAX + 1;
   localparam int POS_W      = $clog2(NEEDLE_MAX + 2);
   localparam int IDX_W      = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;

   // separator bytes
   localparam logic [7:0] SPACE_BYTE = 8'h20;
   localparam logic [7:0] DASH_BYTE  = 8'h2D;

   // item commands
   localparam logic CMD_NEEDLE = 1'b0;
   localparam logic CMD_VALUE  = 1'b1;

   // match operators
   typedef enum logic [2:0] {
      OP_EQUALS    = 3'd0,
      OP_INCLUDES  = 3'd1,
      OP_DASH      = 3'd2,
      OP_PREFIX    = 3'd3,
      OP_SUFFIX    = 3'd4,
      OP_SUBSTRING = 3'd5
   } avm_op_type;

   // per-cycle control handed to the cells and the verdict logic
   typedef struct packed {
      logic       take;   // a value byte enters this cycle
      logic       clear;  // value state returns to its start
      logic [7:0] data;   // byte carried by the item
   } avm_cell_ctl_type;

endpackage

`default_nettype wire

FILE: rtl/avm_channels.sv
// valid/ready channel interfaces for request and response items
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

// request channel: needle or value bytes
interface avm_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] data_byte;
   logic       no_byte;
   logic       last;

   modport source (output valid, command, data_byte, no_byte, last, input ready);
   modport sink   (input valid, command, data_byte, no_byte, last, output ready);
endinterface

// response channel: one match result per value
interface avm_rsp_if;
   logic valid;
   logic ready;
   logic matched;
   logic needle_overflow;

   modport source (output valid, matched, needle_overflow, input ready);
   modport sink   (input valid, matched, needle_overflow, output ready);
endinterface

`default_nettype wire

FILE: rtl/avm_cell.sv
// one cell of the matcher chain: a needle byte and a running substring flag
// depends on avm_pkg
`timescale 1ns / 1ps
`default_nettype none

module avm_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  avm_pkg::avm_cell_ctl_type ctl,
   input  logic                      load_hit,
   input  logic                      prev_match,
   output logic                      byte_eq,
   output logic                      match,
   output logic                      match_nxt
);
   import avm_pkg::*;

   logic [7:0] needle_ff;
   logic       match_ff;
   logic       match_in;

   // needle byte, written once when its slot is loaded
   always_ff @(posedge clock) begin
      if (load_hit) begin
         needle_ff <= ctl.data;
      end
   end

   // byte compare against this cell's needle byte
   assign byte_eq = (ctl.data == needle_ff);

   // the newest bytes end with needle[0..this cell] when the neighbor held and this byte fits
   assign match_nxt = ctl.take ? (prev_match && byte_eq) : match_ff;
   assign match_in  = ctl.clear ? 1'b0 : match_nxt;

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign match = match_ff;

endmodule

`default_nettype wire

FILE: rtl/avm_verdict.sv
// value position, prefix, dash and token tracking plus the final operator decision
// depends on avm_pkg
`timescale 1ns / 1ps
`default_nettype none

module avm_verdict (
   input  logic                              clock,
   input  logic                              reset,
   input  avm_pkg::avm_cell_ctl_type         ctl,
   input  logic [avm_pkg::NEEDLE_MAX-1:0]    eq_vec,
   input  logic [avm_pkg::NEEDLE_MAX-1:0]    match_nxt_vec,
   input  logic [avm_pkg::LEN_W-1:0]         needle_len,
   input  avm_pkg::avm_op_type               op,
   output logic                              matched
);
   import avm_pkg::*;

   logic [POS_W-1:0] vp_ff, vp_in, vp_n;
   logic [POS_W-1:0] tp_ff, tp_in, tp_n;
   logic             pse_ff, pse_in, pse_n;
   logic             tse_ff, tse_in, tse_n;
   logic             tf_ff, tf_in, tf_n;
   logic             sf_ff, sf_in, sf_n;
   logic             ds_ff, ds_in, ds_n;

   logic [POS_W-1:0] len_pos;
   logic [LEN_W-1:0] len_m1;
   logic             len_nz;
   logic             tail_sel;
   logic             is_space;
   logic             tok_hit;
   logic             tok_final;
   logic             found;
   logic             eq_final;

   assign len_pos  = POS_W'(needle_len);
   assign len_nz   = (needle_len != '0);
   assign len_m1   = needle_len - LEN_W'(1);
   assign is_space = (ctl.data == SPACE_BYTE);

   // suffix test: the cell at the needle's end reports a full match
   assign tail_sel = len_nz && match_nxt_vec[len_m1[IDX_W-1:0]];

   // value position, prefix and dash
   always_comb begin
      vp_n  = vp_ff;
      pse_n = pse_ff;
      ds_n  = ds_ff;
      if (ctl.take) begin
         if (vp_ff < len_pos) begin
            if (!eq_vec[vp_ff[IDX_W-1:0]]) begin
               pse_n = 1'b0;
            end
         end else if ((vp_ff == len_pos) && (ctl.data == DASH_BYTE)) begin
            ds_n = 1'b1;
         end
         if (vp_ff < POS_W'(POS_SAT)) begin
            vp_n = vp_ff + POS_W'(1);
         end
      end
   end

   // token tracking, closed by a space
   assign tok_hit = (tp_ff != '0) && tse_ff && (tp_ff == len_pos);

   always_comb begin
      tp_n  = tp_ff;
      tse_n = tse_ff;
      tf_n  = tf_ff;
      if (ctl.take) begin
         if (is_space) begin
            tf_n  = tf_ff || tok_hit;
            tp_n  = '0;
            tse_n = 1'b1;
         end else begin
            if (tp_ff < len_pos) begin
               tse_n = tse_ff && eq_vec[tp_ff[IDX_W-1:0]];
            end else begin
               tse_n = 1'b0;
            end
            if (tp_ff < POS_W'(POS_SAT)) begin
               tp_n = tp_ff + POS_W'(1);
            end
         end
      end
   end

   assign sf_n = sf_ff || (ctl.take && tail_sel);

   // decision on the state after this item, with the open token closed
   assign tok_final = (tp_n != '0) && tse_n && (tp_n == len_pos);
   assign found     = tf_n || tok_final;
   assign eq_final  = pse_n && (vp_n == len_pos);

   always_comb begin
      unique case (op)
         OP_EQUALS:    matched = eq_final;
         OP_INCLUDES:  matched = found;
         OP_DASH:      matched = eq_final || (ds_n && pse_n);
         OP_PREFIX:    matched = len_nz && pse_n && (vp_n >= len_pos);
         OP_SUFFIX:    matched = tail_sel;
         OP_SUBSTRING: matched = sf_n;
         default:      matched = 1'b0;
      endcase
   end

   // next state, back to start on clear
   always_comb begin
      if (ctl.clear) begin
         vp_in  = '0;
         tp_in  = '0;
         pse_in = 1'b1;
         tse_in = 1'b1;
         tf_in  = 1'b0;
         sf_in  = 1'b0;
         ds_in  = 1'b0;
      end else begin
         vp_in  = vp_n;
         tp_in  = tp_n;
         pse_in = pse_n;
         tse_in = tse_n;
         tf_in  = tf_n;
         sf_in  = sf_n;
         ds_in  = ds_n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_ff  <= '0;
         tp_ff  <= '0;
         pse_ff <= 1'b1;
         tse_ff <= 1'b1;
         tf_ff  <= 1'b0;
         sf_ff  <= 1'b0;
         ds_ff  <= 1'b0;
      end else begin
         vp_ff  <= vp_in;
         tp_ff  <= tp_in;
         pse_ff <= pse_in;
         tse_ff <= tse_in;
         tf_ff  <= tf_in;
         sf_ff  <= sf_in;
         ds_ff  <= ds_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/attribute_value_matcher_unit.sv
// top level of the attribute value matcher: needle control, cell chain, result register
// depends on avm_pkg, avm_channels, avm_cell, avm_verdict and the assertion macro header
//
//   channel   dir   handshake      payload
//   req_chan  in    valid/ready    command, data_byte, no_byte, last
//   rsp_chan  out   valid/ready    matched, needle_overflow
//   csr_*     in    csr_we         csr_wdata = match operator
//
// one item per cycle while req_chan.ready is high; each value byte updates every cell of the chain in the same cycle
// a result leaves through a one-entry output register in the cycle after the value's last item
// req_chan.ready drops only while that register is full and rsp_chan.ready is low
// synchronous reset clears all control state; the needle store itself is not cleared
`timescale 1ns / 1ps
`default_nettype none
`include "attribute_value_matcher_unit_defines.svh"

module attribute_value_matcher_unit (
   input  logic       clock,
   input  logic       reset,
   avm_req_if.sink    req_chan,
   avm_rsp_if.source  rsp_chan,
   input  logic       csr_we,
   input  logic [2:0] csr_wdata
);
   import avm_pkg::*;

   avm_op_type        op_ff;
   logic              needle_open_ff, needle_open_in;
   logic [LEN_W-1:0]  needle_len_ff, needle_len_in;
   logic              ntl_ff, ntl_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_matched_ff;
   logic              rsp_overflow_ff;

   logic              req_fire;
   logic              needle_fire;
   logic              value_fire;
   logic              result_fire;
   logic [LEN_W-1:0]  eff_len;
   logic              eff_ntl;
   logic              room;
   logic              verdict_matched;
   avm_cell_ctl_type  ctl;

   logic [NEEDLE_MAX-1:0] eq_vec;
   logic [NEEDLE_MAX-1:0] match_vec;
   logic [NEEDLE_MAX-1:0] match_nxt_vec;
   logic [NEEDLE_MAX-1:0] load_hit;

   // operator register
   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff <= OP_EQUALS;
      end else if (csr_we) begin
         op_ff <= avm_op_type'(csr_wdata);
      end
   end

   // handshake
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign needle_fire    = req_fire && (req_chan.command == CMD_NEEDLE);
   assign value_fire     = req_fire && (req_chan.command == CMD_VALUE);
   assign result_fire    = value_fire && req_chan.last;

   // needle length and overflow, restarted by the first item of a new needle
   assign eff_len = needle_open_ff ? needle_len_ff : '0;
   assign eff_ntl = needle_open_ff ? ntl_ff : 1'b0;
   assign room    = (eff_len < LEN_W'(NEEDLE_MAX));

   always_comb begin
      needle_open_in = needle_open_ff;
      needle_len_in  = needle_len_ff;
      ntl_in         = ntl_ff;
      if (needle_fire) begin
         needle_len_in  = eff_len;
         ntl_in         = eff_ntl;
         needle_open_in = !req_chan.last;
         if (!req_chan.no_byte) begin
            if (room) begin
               needle_len_in = eff_len + LEN_W'(1);
            end else begin
               ntl_in = 1'b1;
            end
         end
      end else if (value_fire) begin
         needle_open_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         needle_open_ff <= 1'b0;
         needle_len_ff  <= '0;
         ntl_ff         <= 1'b0;
      end else begin
         needle_open_ff <= needle_open_in;
         needle_len_ff  <= needle_len_in;
         ntl_ff         <= ntl_in;
      end
   end

   // chain control
   assign ctl.take  = value_fire && !req_chan.no_byte;
   assign ctl.clear = (needle_fire && !needle_open_ff) || result_fire;
   assign ctl.data  = req_chan.data_byte;

   // row of cells, each passing its substring flag to the next
   for (genvar j = 0; j < NEEDLE_MAX; j++) begin : g_cell
      assign load_hit[j] = needle_fire && !req_chan.no_byte && (eff_len == LEN_W'(j));

      if (j == 0) begin : g_head
         avm_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .load_hit   (load_hit[j]),
            .prev_match (1'b1),
            .byte_eq    (eq_vec[j]),
            .match      (match_vec[j]),
            .match_nxt  (match_nxt_vec[j])
         );
      end else begin : g_body
         avm_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .load_hit   (load_hit[j]),
            .prev_match (match_vec[j-1]),
            .byte_eq    (eq_vec[j]),
            .match      (match_vec[j]),
            .match_nxt  (match_nxt_vec[j])
         );
      end
   end

   // scalar tracking and operator decision
   avm_verdict u_verdict (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .eq_vec        (eq_vec),
      .match_nxt_vec (match_nxt_vec),
      .needle_len    (needle_len_ff),
      .op            (op_ff),
      .matched       (verdict_matched)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (result_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result_fire) begin
         rsp_matched_ff  <= verdict_matched && !ntl_ff;
         rsp_overflow_ff <= ntl_ff;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.matched         = rsp_matched_ff;
   assign rsp_chan.needle_overflow = rsp_overflow_ff;

   // checks
   `AVM_ASSERT_NEXT(a_result_follows, clock, reset, result_fire, rsp_valid_ff)
   `AVM_ASSERT_NOW(a_stall_blocks, clock, reset, rsp_valid_ff && !rsp_chan.ready,
                   !req_chan.ready)
   `AVM_ASSERT_NOW(a_overflow_full, clock, reset, ntl_ff, needle_len_ff == LEN_W'(NEEDLE_MAX))
   `AVM_ASSERT_NOW(a_overflow_no_match, clock, reset, rsp_valid_ff,
                   !(rsp_matched_ff && rsp_overflow_ff))

endmodule

`default_nettype wire

FILE: tb/avm_match_checker.sv
// scoreboard for the attribute value matcher: tracks the needle and value state per item
// depends on avm_pkg and the avm_req_if / avm_rsp_if channel interfaces
`timescale 1ns / 1ps

module avm_match_checker (
   input  logic        clock,
   input  logic        reset,
   avm_req_if          req_mon,
   avm_rsp_if          rsp_mon,
   input  logic        csr_we,
   input  logic [2:0]  csr_wdata,
   output int unsigned fault_count,
   output int unsigned awaited_count
);
   import avm_pkg::*;

   localparam int unsigned REPORT_LIMIT = 10;

   typedef struct packed {
      logic matched;
      logic overflow;
   } match_result_type;

   // predicted needle and value state
   logic [7:0]    needle_buf [NEEDLE_MAX];
   int unsigned   needle_len;
   bit            needle_over;
   bit            needle_loading;
   logic [7:0]    recent [NEEDLE_MAX + 1];  // newest value byte at index 0
   int unsigned   seen_len;
   bit            lead_equal;
   int unsigned   word_len;
   bit            word_equal;
   bit            word_hit;
   bit            inner_hit;
   bit            hyphen_hit;
   logic [2:0]    oper;

   match_result_type expected_matches [$];

   // value state back to its start
   task automatic clear_track();
      for (int k = 0; k <= NEEDLE_MAX; k++) recent[k] = 8'h00;
      seen_len   = 0;
      lead_equal = 1'b1;
      word_len   = 0;
      word_equal = 1'b1;
      word_hit   = 1'b0;
      inner_hit  = 1'b0;
      hyphen_hit = 1'b0;
   endtask

   // newest bytes of the value equal the whole needle
   function automatic bit tail_equal();
      int unsigned k;
      if (needle_len == 0 || seen_len < needle_len) return 1'b0;
      for (k = 0; k < needle_len; k++) begin
         if (recent[k] != needle_buf[needle_len - 1 - k]) return 1'b0;
      end
      return 1'b1;
   endfunction

   // a space or the end of the value ends the current token
   task automatic close_word();
      if (word_len > 0 && word_equal && word_len == needle_len) word_hit = 1'b1;
      word_len   = 0;
      word_equal = 1'b1;
   endtask

   task automatic take_byte(input logic [7:0] b);
      int k;
      if (seen_len < needle_len) begin
         if (b != needle_buf[seen_len]) lead_equal = 1'b0;
      end else if (seen_len == needle_len && b == DASH_BYTE) begin
         hyphen_hit = 1'b1;
      end
      for (k = NEEDLE_MAX; k > 0; k--) recent[k] = recent[k - 1];
      recent[0] = b;
      if (seen_len < POS_SAT) seen_len++;

      if (b == SPACE_BYTE) begin
         close_word();
      end else begin
         if (word_len < needle_len) begin
            if (b != needle_buf[word_len]) word_equal = 1'b0;
         end else begin
            word_equal = 1'b0;
         end
         if (word_len < POS_SAT) word_len++;
      end

      if (tail_equal()) inner_hit = 1'b1;
   endtask

   // operator verdict at the end of a value
   task automatic judge_value(output bit hit);
      bit whole;
      close_word();
      whole = lead_equal && seen_len == needle_len;
      case (oper)
         OP_EQUALS:    hit = whole;
         OP_INCLUDES:  hit = word_hit;
         OP_DASH:      hit = whole || (hyphen_hit && lead_equal);
         OP_PREFIX:    hit = needle_len > 0 && lead_equal && seen_len >= needle_len;
         OP_SUFFIX:    hit = tail_equal();
         OP_SUBSTRING: hit = inner_hit;
         default:      hit = 1'b0;
      endcase
   endtask

   task automatic absorb_item(input logic cmd, input logic [7:0] b, input logic nb,
                              input logic lst);
      match_result_type r;
      bit hit;
      if (cmd == CMD_NEEDLE) begin
         // first needle item after a closed needle starts a fresh one
         if (!needle_loading) begin
            needle_loading = 1'b1;
            needle_len     = 0;
            needle_over    = 1'b0;
            clear_track();
         end
         if (!nb) begin
            if (needle_len < NEEDLE_MAX) begin
               needle_buf[needle_len] = b;
               needle_len++;
            end else begin
               needle_over = 1'b1;
            end
         end
         if (lst) needle_loading = 1'b0;
      end else begin
         needle_loading = 1'b0;
         if (!nb) take_byte(b);
         if (lst) begin
            judge_value(hit);
            r.matched  = hit && !needle_over;
            r.overflow = needle_over;
            expected_matches.push_back(r);
            clear_track();
         end
      end
   endtask

   task automatic log_fault(input string msg);
      if (fault_count < REPORT_LIMIT) $display("mismatch at %0t ns: %s", $time, msg);
      fault_count++;
   endtask

   // compare results first, then predict from the item taken on the same edge
   always @(posedge clock) begin
      match_result_type got;
      match_result_type want;
      if (reset) begin
         oper           = OP_EQUALS;
         needle_len     = 0;
         needle_over    = 1'b0;
         needle_loading = 1'b0;
         clear_track();
         expected_matches.delete();
         fault_count    = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.matched  = rsp_mon.matched;
            got.overflow = rsp_mon.needle_overflow;
            if (expected_matches.size() == 0) begin
               log_fault($sformatf("unexpected result matched=%0b overflow=%0b",
                                   got.matched, got.overflow));
            end else begin
               want = expected_matches.pop_front();
               if (got.matched !== want.matched || got.overflow !== want.overflow)
                  log_fault($sformatf(
                     "expected matched=%0b overflow=%0b, got matched=%0b overflow=%0b",
                     want.matched, want.overflow, got.matched, got.overflow));
            end
         end
         if (req_mon.valid && req_mon.ready)
            absorb_item(req_mon.command, req_mon.data_byte, req_mon.no_byte, req_mon.last);
         if (csr_we) oper = csr_wdata;
      end
      awaited_count = expected_matches.size();
   end

endmodule

FILE: tb/tb_attribute_value_matcher_unit.sv
// testbench top for the attribute value matcher: clock, reset, item stimulus and verdict
// depends on avm_pkg, avm_channels, avm_match_checker and the attribute_value_matcher_unit rtl
`timescale 1ns / 1ps

module tb_attribute_value_matcher_unit;
   import avm_pkg::*;

   typedef logic [7:0] byte_q_type [$];

   // operator codes outside the defined set
   localparam logic [2:0] OP_RESERVED_LO = 3'd6;
   localparam logic [2:0] OP_RESERVED_HI = 3'd7;

   localparam logic [7:0] CH_A     = 8'h61;
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_C     = 8'h63;
   localparam logic [7:0] CH_X     = 8'h78;
   localparam logic [7:0] BYTE_MIN = 8'h00;
   localparam logic [7:0] BYTE_MAX = 8'hFF;

   localparam int          RESET_CYCLES  = 6;
   localparam int          SETTLE_CYCLES = 4;
   localparam int          DRAIN_CYCLES  = 8;
   localparam int          PHASES        = 12;
   localparam int          PHASE_ITEMS   = 155;
   localparam int          STEADY_FIRST  = 4;
   localparam int          STEADY_LAST   = 5;
   localparam int          IDLE_PCT      = 8;
   localparam int unsigned CYCLE_LIMIT   = 400000;

   localparam logic [2:0] FIXED_OPS [6] = '{OP_EQUALS, OP_SUBSTRING, OP_INCLUDES,
                                             OP_DASH, OP_PREFIX, OP_SUFFIX};

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_we;
   logic [2:0]  csr_wdata;
   int unsigned fault_count;
   int unsigned awaited_count;
   int unsigned cycle_count;
   int unsigned items_sent;
   bit          steady;

   avm_req_if req_chan ();
   avm_rsp_if rsp_chan ();

   attribute_value_matcher_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   avm_match_checker watch (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .fault_count   (fault_count),
      .awaited_count (awaited_count)
   );

   always #1 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // run limit
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("FAILURE");
      $finish;
   end

   // result side stalls at random except in steady phases
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // mostly separator-rich bytes, sometimes any byte
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0, 1:    return CH_A;
         2:       return CH_B;
         3:       return DASH_BYTE;
         4:       return SPACE_BYTE;
         5:       return CH_C;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // called at a falling edge, returns at the falling edge after the item is taken
   task automatic send_item(input logic cmd, input logic [7:0] b, input logic nb,
                            input logic lst);
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.command   <= cmd;
      req_chan.data_byte <= b;
      req_chan.no_byte   <= nb;
      req_chan.last      <= lst;
      do @(posedge clock); while (!req_chan.ready);
      if (!nb || lst) items_sent++;
      @(negedge clock);
   endtask

   // one needle or value; an open string is left without its last item
   task automatic send_string(input logic cmd, input byte_q_type text, input bit closed);
      bit split_end;
      split_end = closed && ($urandom_range(0, 9) == 0);
      foreach (text[i]) begin
         if ($urandom_range(0, 99) < 4) send_item(cmd, pick_byte(), 1'b1, 1'b0);
         send_item(cmd, text[i], 1'b0, closed && !split_end && i == text.size() - 1);
      end
      if (closed && (split_end || text.size() == 0)) send_item(cmd, pick_byte(), 1'b1, 1'b1);
   endtask

   // operator write once all results are out and the block has settled
   task automatic set_operator(input logic [2:0] op);
      req_chan.valid <= 1'b0;
      while (awaited_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= op;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      byte_q_type  needle_text;
      byte_q_type  value_text;
      int unsigned phase_end;
      int          needle_size;
      int          value_count;
      int          pos;

      req_chan.valid     = 1'b0;
      req_chan.command   = CMD_NEEDLE;
      req_chan.data_byte = BYTE_MIN;
      req_chan.no_byte   = 1'b0;
      req_chan.last      = 1'b0;
      csr_we             = 1'b0;
      csr_wdata          = OP_EQUALS;
      reset              = 1'b1;
      steady             = 1'b0;
      items_sent         = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty value against the empty needle left by reset
      set_operator(OP_EQUALS);
      send_item(CMD_VALUE, BYTE_MIN, 1'b1, 1'b1);
      send_item(CMD_NEEDLE, CH_A, 1'b0, 1'b0);
      send_item(CMD_NEEDLE, CH_B, 1'b0, 1'b1);
      send_item(CMD_VALUE, CH_A, 1'b0, 1'b0);
      send_item(CMD_VALUE, CH_B, 1'b0, 1'b1);

      // needle followed by a hyphen
      set_operator(OP_DASH);
      send_item(CMD_VALUE, CH_A, 1'b0, 1'b0);
      send_item(CMD_VALUE, CH_B, 1'b0, 1'b0);
      send_item(CMD_VALUE, DASH_BYTE, 1'b0, 1'b0);
      send_item(CMD_VALUE, CH_C, 1'b0, 1'b1);

      // needle as the second token
      set_operator(OP_INCLUDES);
      send_item(CMD_VALUE, CH_X, 1'b0, 1'b0);
      send_item(CMD_VALUE, SPACE_BYTE, 1'b0, 1'b0);
      send_item(CMD_VALUE, CH_A, 1'b0, 1'b0);
      send_item(CMD_VALUE, CH_B, 1'b0, 1'b1);

      // prefix with an empty item in the middle of the value
      set_operator(OP_PREFIX);
      send_item(CMD_VALUE, CH_A, 1'b0, 1'b0);
      send_item(CMD_VALUE, BYTE_MIN, 1'b1, 1'b0);
      send_item(CMD_VALUE, CH_B, 1'b0, 1'b0);
      send_item(CMD_VALUE, BYTE_MAX, 1'b0, 1'b1);

      // a new needle drops the value in progress
      set_operator(OP_SUFFIX);
      send_item(CMD_VALUE, CH_A, 1'b0, 1'b0);
      send_item(CMD_NEEDLE, BYTE_MAX, 1'b0, 1'b1);
      send_item(CMD_VALUE, BYTE_MIN, 1'b0, 1'b0);
      send_item(CMD_VALUE, BYTE_MAX, 1'b0, 1'b1);

      // value item closes a needle still open, then an empty value
      set_operator(OP_SUBSTRING);
      send_item(CMD_NEEDLE, BYTE_MIN, 1'b0, 1'b0);
      send_item(CMD_VALUE, BYTE_MIN, 1'b0, 1'b1);
      send_item(CMD_VALUE, BYTE_MIN, 1'b1, 1'b1);

      // undefined operator code never matches
      set_operator(OP_RESERVED_LO);
      send_item(CMD_VALUE, BYTE_MIN, 1'b0, 1'b1);

      // random phases, each under one operator setting
      for (int phase = 0; phase < PHASES; phase++) begin
         steady = (phase == STEADY_FIRST || phase == STEADY_LAST);
         if (phase < 6)
            set_operator(FIXED_OPS[phase]);
         else if (phase == PHASES - 1)
            set_operator(OP_RESERVED_HI);
         else
            set_operator(3'($urandom_range(OP_EQUALS, OP_SUBSTRING)));

         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) begin
            if ($urandom_range(0, 9) == 0) begin
               // noise: arbitrary items
               repeat ($urandom_range(1, 6))
                  send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                            $urandom_range(0, 9) == 0, $urandom_range(0, 2) == 0);
            end else begin
               case ($urandom_range(0, 9))
                  0:       needle_size = 0;
                  1:       needle_size = $urandom_range(5, NEEDLE_MAX);
                  2:       needle_size = $urandom_range(NEEDLE_MAX + 1, NEEDLE_MAX + 4);
                  default: needle_size = $urandom_range(1, 4);
               endcase
               needle_text.delete();
               repeat (needle_size) needle_text.push_back(pick_byte());
               send_string(CMD_NEEDLE, needle_text, $urandom_range(0, 11) != 0);

               value_count = $urandom_range(1, 4);
               for (int v = 0; v < value_count; v++) begin
                  value_text.delete();
                  case ($urandom_range(0, 8))
                     0: value_text = needle_text;
                     1: begin
                        value_text = needle_text;
                        value_text.push_back(DASH_BYTE);
                        repeat ($urandom_range(0, 3)) value_text.push_back(pick_byte());
                     end
                     2: begin
                        value_text = needle_text;
                        repeat ($urandom_range(1, 4)) value_text.push_back(pick_byte());
                     end
                     3: begin
                        repeat ($urandom_range(1, 4)) value_text.push_back(pick_byte());
                        value_text = {value_text, needle_text};
                     end
                     4: begin
                        repeat ($urandom_range(1, 3)) value_text.push_back(pick_byte());
                        value_text = {value_text, needle_text};
                        repeat ($urandom_range(1, 3)) value_text.push_back(pick_byte());
                     end
                     5: begin
                        // space separated tokens, some equal to the needle
                        repeat ($urandom_range(1, 4)) begin
                           if (value_text.size() > 0 || $urandom_range(0, 3) == 0)
                              value_text.push_back(SPACE_BYTE);
                           if ($urandom_range(0, 1))
                              value_text = {value_text, needle_text};
                           else
                              repeat ($urandom_range(0, 4)) value_text.push_back(pick_byte());
                        end
                     end
                     6: repeat ($urandom_range(0, 6)) value_text.push_back(pick_byte());
                     7: begin
                        // near miss: one bit flipped or the last byte cut
                        value_text = needle_text;
                        if (value_text.size() > 0) begin
                           pos = $urandom_range(0, value_text.size() - 1);
                           if ($urandom_range(0, 1))
                              value_text[pos] = value_text[pos] ^ (8'h01 << $urandom_range(0, 7));
                           else
                              void'(value_text.pop_back());
                        end
                     end
                     default: begin
                        // long value, past position saturation
                        repeat ($urandom_range(NEEDLE_MAX + 2, 30))
                           value_text.push_back(pick_byte());
                        if ($urandom_range(0, 1)) value_text = {value_text, needle_text};
                     end
                  endcase

                  // now and then a value is abandoned and the next needle drops it
                  if ($urandom_range(0, 19) == 0) begin
                     send_string(CMD_VALUE, value_text, 1'b0);
                     break;
                  end
                  send_string(CMD_VALUE, value_text, 1'b1);
               end
            end
         end
      end

      // drain the remaining results
      steady = 1'b0;
      req_chan.valid <= 1'b0;
      while (awaited_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (fault_count == 0 && awaited_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
